// ----- hw/rtl/ghtbl_pkg.sv -----
`timescale 1ns / 1ps

package ghtbl_pkg;

    // Table geometry
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int OWNER_W  = 16;
    localparam int GEN_W    = 32;
    localparam int PART_W   = 32;
    localparam int HANDLE_W = GEN_W + PART_W;

    // One RAM word holds the owner in the low bits and the generation above it
    localparam int ENTRY_W = OWNER_W + GEN_W;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_RAW  = OWNER_W + HANDLE_W;
    localparam int IN_DATA_W    = ((IN_DATA_RAW + 7) / 8) * 8;
    localparam int OUT_DATA_RAW = HANDLE_W + OWNER_W;
    localparam int OUT_DATA_W   = ((OUT_DATA_RAW + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_FREE   = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLAIM  = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_EXEC   = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

endpackage

// ----- hw/rtl/ghtbl_ram.sv -----
`timescale 1ns / 1ps

module ghtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/generation_tagged_handle_table.sv -----
`timescale 1ns / 1ps

// Generation-tagged handle table.
// Input channel (s_*): one beat is one command. s_tuser carries the mode
// (allocate, free, lookup, claim); s_tdata carries owner_id and handle_in.
// Output channel (m_*): exactly one result beat per command, in order.
// m_tdata carries handle_out and owner_out, m_tuser carries the found flag.
// Sequence: a well-formed free, lookup or claim goes from decode, where the
// slot is read, to execute and then to the response; a malformed handle, or an
// allocate with owner zero, goes from decode straight to the response. An
// allocate with an owner walks the occupancy vector one slot per cycle from the
// rotating search pointer, and a full table answers not found after a whole lap.
// A command that reaches a slot reads it; allocate, and a matching free or claim, write it back.
// Throughput: one command at a time; s_tready is high only while idle, so the
// next beat is taken only once the result has entered the output register.
// Reset: all slots free with generation zero (a per-slot valid bit masks the
// RAM until the slot is first written), search pointer at slot zero. Nothing
// sweeps the RAM, so the block is ready right after reset.
// Stall: a result waits in the output register while m_tready is low; the
// next command is still accepted and runs up to its result, then holds.
module generation_tagged_handle_table_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: owner_id [15:0], handle_in [79:16]
    input  logic [ghtbl_pkg::IN_DATA_W-1:0]    s_tdata,
    // s_tuser: mode [1:0]
    input  logic [ghtbl_pkg::MODE_W-1:0]       s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: handle_out [63:0], owner_out [79:64]
    output logic [ghtbl_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser: found [0]
    output logic                               m_tuser
);

    import ghtbl_pkg::*;

    // Control state
    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      search_reg, search_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [SLOT_W-1:0]      count_reg, count_next;
    logic [SLOT_COUNT-1:0]  occupied_reg, occupied_next;
    logic [SLOT_COUNT-1:0]  written_reg, written_next;
    logic                   out_valid_reg, out_valid_next;

    // Command and result payload
    mode_t                  mode_reg, mode_next;
    logic [OWNER_W-1:0]     owner_reg, owner_next;
    logic [HANDLE_W-1:0]    handle_reg, handle_next;
    logic [HANDLE_W-1:0]    res_handle_reg, res_handle_next;
    logic [OWNER_W-1:0]     res_owner_reg, res_owner_next;
    logic                   res_found_reg, res_found_next;
    logic [HANDLE_W-1:0]    out_handle_reg, out_handle_next;
    logic [OWNER_W-1:0]     out_owner_reg, out_owner_next;
    logic                   out_found_reg, out_found_next;

    // Slot RAM port
    logic                   ram_wr_en;
    logic [SLOT_W-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0]     ram_wr_data;
    logic                   ram_rd_en;
    logic [SLOT_W-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0]     ram_rd_data;

    // Handle decode and slot arithmetic
    logic [PART_W-1:0]      part;
    logic [GEN_W-1:0]       gen_in;
    logic                   handle_bad;
    logic [SLOT_W-1:0]      decoded_slot;
    logic [GEN_W-1:0]       cur_gen;
    logic [OWNER_W-1:0]     cur_owner;
    logic [GEN_W-1:0]       gen_inc;
    logic [GEN_W-1:0]       gen_bumped;
    logic                   gen_match;
    logic [SLOT_W-1:0]      slot_after;

    ghtbl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign part         = handle_reg[PART_W-1:0];
    assign gen_in       = handle_reg[HANDLE_W-1:PART_W];
    assign handle_bad   = (part == '0) || (part > PART_W'(SLOT_COUNT)) || (gen_in == '0);
    assign decoded_slot = SLOT_W'(part - PART_W'(1));

    // A slot never written reads as free with generation zero
    assign cur_owner  = written_reg[slot_reg] ? ram_rd_data[OWNER_W-1:0] : '0;
    assign cur_gen    = written_reg[slot_reg] ? ram_rd_data[ENTRY_W-1:OWNER_W] : '0;
    assign gen_inc    = cur_gen + GEN_W'(1);
    assign gen_bumped = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
    assign gen_match  = (cur_gen == gen_in);

    assign slot_after   = (slot_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_reg + SLOT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        search_next     = search_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        occupied_next   = occupied_reg;
        written_next    = written_reg;
        out_valid_next  = out_valid_reg;
        mode_next       = mode_reg;
        owner_next      = owner_reg;
        handle_next     = handle_reg;
        res_handle_next = res_handle_reg;
        res_owner_next  = res_owner_reg;
        res_found_next  = res_found_reg;
        out_handle_next = out_handle_reg;
        out_owner_next  = out_owner_reg;
        out_found_next  = out_found_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = slot_reg;
        ram_wr_data = {cur_gen, cur_owner};
        ram_rd_en   = 1'b0;
        ram_rd_addr = slot_reg;

        // Drop the output beat once taken
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next   = mode_t'(s_tuser);
                    owner_next  = s_tdata[OWNER_W-1:0];
                    handle_next = s_tdata[OWNER_W+HANDLE_W-1:OWNER_W];
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                res_handle_next = '0;
                res_owner_next  = '0;
                res_found_next  = 1'b0;
                if (mode_reg == MODE_ALLOC)
                begin
                    if (owner_reg == '0)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        slot_next  = search_reg;
                        count_next = '0;
                        state_next = ST_SCAN;
                    end
                end
                else if (handle_bad)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    // Fetch the addressed slot
                    slot_next   = decoded_slot;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = decoded_slot;
                    state_next  = ST_EXEC;
                end
            end

            ST_SCAN:
            begin
                // Walk the occupancy vector one slot per cycle
                if (!occupied_reg[slot_reg])
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = slot_reg;
                    state_next  = ST_EXEC;
                end
                else if (count_reg == SLOT_W'(SLOT_COUNT - 1))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    slot_next  = slot_after;
                    count_next = count_reg + SLOT_W'(1);
                end
            end

            ST_EXEC:
            begin
                state_next = ST_RESP;
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        ram_wr_en               = 1'b1;
                        ram_wr_data             = {gen_bumped, owner_reg};
                        written_next[slot_reg]  = 1'b1;
                        occupied_next[slot_reg] = 1'b1;
                        search_next             = slot_after;
                        res_handle_next         = {gen_bumped,
                                                   PART_W'(slot_reg) + PART_W'(1)};
                        res_found_next          = 1'b1;
                    end
                    MODE_FREE:
                    begin
                        if (gen_match && (owner_reg != '0) && (cur_owner == owner_reg))
                        begin
                            ram_wr_en               = 1'b1;
                            ram_wr_data             = {cur_gen, OWNER_W'(0)};
                            written_next[slot_reg]  = 1'b1;
                            occupied_next[slot_reg] = 1'b0;
                            res_found_next          = 1'b1;
                        end
                    end
                    MODE_LOOKUP:
                    begin
                        if (gen_match)
                        begin
                            res_owner_next = cur_owner;
                            res_found_next = (cur_owner != '0);
                        end
                    end
                    MODE_CLAIM:
                    begin
                        if (gen_match)
                        begin
                            res_owner_next          = cur_owner;
                            res_found_next          = (cur_owner != '0);
                            ram_wr_en               = 1'b1;
                            ram_wr_data             = {cur_gen, OWNER_W'(0)};
                            written_next[slot_reg]  = 1'b1;
                            occupied_next[slot_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_RESP:
            begin
                // Hold the result until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_handle_next = res_handle_reg;
                    out_owner_next  = res_owner_reg;
                    out_found_next  = res_found_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            search_reg    <= '0;
            slot_reg      <= '0;
            count_reg     <= '0;
            occupied_reg  <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            search_reg    <= search_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            occupied_reg  <= occupied_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        owner_reg      <= owner_next;
        handle_reg     <= handle_next;
        res_handle_reg <= res_handle_next;
        res_owner_reg  <= res_owner_next;
        res_found_reg  <= res_found_next;
        out_handle_reg <= out_handle_next;
        out_owner_reg  <= out_owner_next;
        out_found_reg  <= out_found_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_owner_reg, out_handle_reg});
    assign m_tuser  = out_found_reg;

endmodule

// ----- tb/sv/tb_generation_tagged_handle_table_core.sv -----
`timescale 1ns / 1ps

module tb_generation_tagged_handle_table_core;
    import ghtbl_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = SLOT_COUNT + 16;   // longest allocate scan plus margin
    localparam int IDLE_PCT = 26;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        mode_t               mode;
        logic [OWNER_W-1:0]  owner;
        logic [HANDLE_W-1:0] handle;
    } table_cmd_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [OWNER_W-1:0]  owner_out;
        logic                found;
    } table_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // s_tdata: owner_id [15:0], handle_in [79:16]
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // s_tuser: mode [1:0]
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: handle_out [63:0], owner_out [79:64]
    logic [OUT_DATA_W-1:0] m_tdata;
    // m_tuser: found [0]
    logic                  m_tuser;

    // Commands waiting for the sender, and results owed by the block
    table_cmd_t    cmd_queue[$];
    table_result_t expected_results[$];

    // Shadow copy of the slot table, advanced at each accepted command
    logic [OWNER_W-1:0] owner_table [SLOT_COUNT];
    logic [GEN_W-1:0]   gen_table [SLOT_COUNT];
    int                 scan_ptr;

    int mismatches = 0;
    int cycles = 0;
    bit steady = 1'b0;   // when set, neither side inserts idle cycles

    generation_tagged_handle_table_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one command to the shadow table and return the result it must produce.
    function automatic table_result_t apply_table_command(table_cmd_t c);
        table_result_t r;
        logic [PART_W-1:0] part;
        logic [GEN_W-1:0]  g;
        int idx;
        int s;
        bit placed;
        r = '0;
        placed = 1'b0;
        if (c.mode == MODE_ALLOC)
        begin
            // Scan from the rotating pointer for the first free slot
            if (c.owner != '0)
            begin
                for (int k = 0; k < SLOT_COUNT; k++)
                begin
                    s = (scan_ptr + k) % SLOT_COUNT;
                    if (!placed && owner_table[s] == '0)
                    begin
                        gen_table[s] = gen_table[s] + 1'b1;
                        // generation never lands on zero
                        if (gen_table[s] == '0)
                            gen_table[s] = 1;
                        owner_table[s] = c.owner;
                        scan_ptr = (s + 1) % SLOT_COUNT;
                        r.handle_out = {gen_table[s], PART_W'(s + 1)};
                        r.found = 1'b1;
                        placed = 1'b1;
                    end
                end
            end
        end
        else
        begin
            part = c.handle[PART_W-1:0];
            g = c.handle[HANDLE_W-1:PART_W];
            // Drop malformed handles: zero slot part, slot past the table, zero generation
            if (part != '0 && part <= SLOT_COUNT && g != '0)
            begin
                idx = int'(part) - 1;
                if (gen_table[idx] == g)
                begin
                    if (c.mode == MODE_FREE)
                    begin
                        // release only on a matching, nonzero owner
                        if (c.owner != '0 && owner_table[idx] == c.owner)
                        begin
                            owner_table[idx] = '0;
                            r.found = 1'b1;
                        end
                    end
                    else
                    begin
                        r.owner_out = owner_table[idx];
                        r.found = (owner_table[idx] != '0);
                        if (c.mode == MODE_CLAIM)
                            owner_table[idx] = '0;
                    end
                end
            end
        end
        return r;
    endfunction

    // Sender: raise tvalid at a falling edge, hold it until the beat is taken.
    always @(negedge clk)
    begin
        if (rst_n && !s_tvalid && cmd_queue.size() > 0 &&
            (steady || $urandom_range(99) >= IDLE_PCT))
        begin
            s_tvalid <= 1'b1;
            s_tuser  <= cmd_queue[0].mode;
            s_tdata  <= {cmd_queue[0].handle, cmd_queue[0].owner};
        end
    end

    // Accepted command beat: advance the shadow table and log the owed result.
    always @(posedge clk)
    begin : accept_beat
        table_cmd_t c;
        if (s_tvalid && s_tready)
        begin
            c = cmd_queue.pop_front();
            expected_results.push_back(apply_table_command(c));
            s_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure, changed at falling edges only.
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Result beat: compare field by field with the oldest owed result.
    always @(posedge clk)
    begin : check_beat
        table_result_t want;
        table_result_t got;
        if (m_tvalid && m_tready)
        begin
            got.handle_out = m_tdata[HANDLE_W-1:0];
            got.owner_out  = m_tdata[HANDLE_W+OWNER_W-1:HANDLE_W];
            got.found      = m_tuser;
            if (expected_results.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result beat: handle %h owner %h found %b",
                             got.handle_out, got.owner_out, got.found);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("result mismatch: exp handle %h owner %h found %b, got handle %h owner %h found %b",
                                 want.handle_out, want.owner_out, want.found,
                                 got.handle_out, got.owner_out, got.found);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Block until the sender has taken everything queued; the shadow table is then current.
    task automatic wait_sender_idle();
        @(posedge clk);
        #0.5;
        while (cmd_queue.size() != 0)
        begin
            @(posedge clk);
            #0.5;
        end
    endtask

    // Block until every owed result has come back.
    task automatic wait_all_done();
        while (cmd_queue.size() != 0 || expected_results.size() != 0)
        begin
            @(posedge clk);
            #0.5;
        end
    endtask

    task automatic push_cmd(mode_t m, logic [OWNER_W-1:0] who, logic [HANDLE_W-1:0] h);
        table_cmd_t c;
        wait_sender_idle();
        c.mode = m;
        c.owner = who;
        c.handle = h;
        cmd_queue.push_back(c);
    endtask

    // Build a handle that names a known slot, occupied ones first; return its owner too.
    function automatic logic [HANDLE_W-1:0] known_handle(output logic [OWNER_W-1:0] who);
        int start;
        int s;
        start = $urandom_range(SLOT_COUNT - 1);
        who = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            s = (start + k) % SLOT_COUNT;
            if (owner_table[s] != '0)
            begin
                who = owner_table[s];
                return {gen_table[s], PART_W'(s + 1)};
            end
        end
        // nothing occupied: fall back to a released slot with a live generation
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            s = (start + k) % SLOT_COUNT;
            if (gen_table[s] != '0)
                return {gen_table[s], PART_W'(s + 1)};
        end
        return {GEN_W'(1), PART_W'(1)};
    endfunction

    // One random command; alloc_pct sets the share of allocations.
    task automatic push_random_cmd(int alloc_pct);
        logic [OWNER_W-1:0]  who;
        logic [OWNER_W-1:0]  holder;
        logic [HANDLE_W-1:0] h;
        logic [GEN_W-1:0]    g;
        mode_t m;
        int pick;
        wait_sender_idle();
        who = $urandom_range(65535);
        h = {$urandom, $urandom};
        if ($urandom_range(99) < alloc_pct)
        begin
            m = MODE_ALLOC;
            if ($urandom_range(99) < 5)
                who = '0;
            else if (who == '0)
                who = 16'h0001;
        end
        else
        begin
            m = mode_t'($urandom_range(3, 1));
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                h = known_handle(holder);
                // free: mostly the right owner, sometimes a wrong or zero one
                if ($urandom_range(99) < 75)
                    who = holder;
                else if ($urandom_range(1) == 0)
                    who = '0;
            end
            else if (pick < 80)
            begin
                // stale generation on a known slot
                h = known_handle(holder);
                g = h[HANDLE_W-1:PART_W] + GEN_W'($urandom_range(3, 1));
                h[HANDLE_W-1:PART_W] = g;
                who = holder;
            end
            else if (pick < 90)
            begin
                // malformed handle
                case ($urandom_range(3))
                    0: h[PART_W-1:0] = '0;
                    1: h[PART_W-1:0] = PART_W'(SLOT_COUNT + 1);
                    2: h[PART_W-1:0] = PART_W'($urandom_range(32'hFFFF_FFFF, SLOT_COUNT + 1));
                    default:
                    begin
                        h[HANDLE_W-1:PART_W] = '0;
                        h[PART_W-1:0] = PART_W'($urandom_range(SLOT_COUNT, 1));
                    end
                endcase
            end
        end
        cmd_queue.push_back('{mode: m, owner: who, handle: h});
    endtask

    initial
    begin
        int chunk_len [8] = '{90, 40, 50, 50, 60, 50, 60, 50};
        int chunk_pct [8] = '{92, 20, 55, 35, 80, 15, 60, 40};
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            owner_table[i] = '0;
            gen_table[i] = '0;
        end
        scan_ptr = 0;

        // Hold reset, then release it on a falling edge
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: malformed handles, owner zero, stale and released handles
        push_cmd(MODE_LOOKUP, 16'h0000, 64'h0);
        push_cmd(MODE_ALLOC,  16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cmd(MODE_ALLOC,  16'hFFFF, 64'h0);
        push_cmd(MODE_ALLOC,  16'h0001, 64'h0);
        push_cmd(MODE_LOOKUP, 16'h0000, {32'd1, 32'd1});
        push_cmd(MODE_LOOKUP, 16'hFFFF, {32'd2, 32'd1});
        push_cmd(MODE_FREE,   16'h0001, {32'd1, 32'd1});
        push_cmd(MODE_FREE,   16'h0000, {32'd1, 32'd1});
        push_cmd(MODE_FREE,   16'hFFFF, {32'd1, 32'd1});
        push_cmd(MODE_FREE,   16'hFFFF, {32'd1, 32'd1});
        push_cmd(MODE_LOOKUP, 16'h0000, {32'd1, 32'd1});
        push_cmd(MODE_CLAIM,  16'h5A5A, {32'd1, 32'd2});
        push_cmd(MODE_CLAIM,  16'h0000, {32'd1, 32'd2});
        push_cmd(MODE_ALLOC,  16'h8000, 64'h0);
        push_cmd(MODE_LOOKUP, 16'h0000, {32'd1, 32'd65});
        push_cmd(MODE_LOOKUP, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cmd(MODE_CLAIM,  16'h0000, {32'd0, 32'd3});
        push_cmd(MODE_FREE,   16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        push_cmd(MODE_ALLOC,  16'h1234, 64'h0);
        push_cmd(MODE_LOOKUP, 16'h0000, {32'd1, 32'd64});
        push_cmd(MODE_CLAIM,  16'h0000, {32'd1, 32'd3});
        push_cmd(MODE_ALLOC,  16'h00FF, 64'h0);
        push_cmd(MODE_ALLOC,  16'hABCD, 64'h0);
        push_cmd(MODE_LOOKUP, 16'h0000, {32'd2, 32'd1});

        // Random: phases of varying allocate pressure; drain fully between phases
        for (int ci = 0; ci < 8; ci++)
        begin
            wait_all_done();
            steady = (ci == 3);
            for (int n = 0; n < chunk_len[ci]; n++)
                push_random_cmd(chunk_pct[ci]);
        end
        steady = 1'b0;

        // Let the last results land, then give a stray beat time to show up
        wait_all_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- generation_tagged_handle_table_core.f -----
hw/rtl/ghtbl_pkg.sv
hw/rtl/ghtbl_ram.sv
hw/rtl/generation_tagged_handle_table.sv
tb/sv/tb_generation_tagged_handle_table_core.sv
